@@ src/srse_pkg.sv @@
package srse_pkg;

  typedef struct packed {
    logic               action;
    logic signed [31:0] first_operand;
    logic signed [31:0] second_operand;
  } srse_req_t;

  typedef struct packed {
    logic signed [42:0] range_sum;
    logic               adds_dropped;
  } srse_rsp_t;

  typedef enum logic [2:0] {
    RD_MID,
    RD_J,
    RD_JM1,
    RD_KM1,
    RD_CHI_M1,
    RD_CLO_M1
  } srse_rd_sel_e;

  typedef enum logic [1:0] {
    PH_ADD,
    PH_QHI,
    PH_QLO
  } srse_phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCMP,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS_RD,
    ST_INS_WR,
    ST_Q_RD_HI,
    ST_Q_RD_LO,
    ST_Q_OUT
  } srse_state_e;

  typedef struct packed {
    logic         ld;
    logic         srch_init;
    logic         srch_incl;
    logic         srch_x_b;
    logic         srch_step;
    logic         j_init_k;
    logic         j_init_u;
    logic         j_inc;
    logic         j_dec;
    srse_rd_sel_e rd_sel;
    logic         wr_en;
    logic         wr_ins;
    logic         u_inc;
    logic         cnt_inc;
    logic         ovf_set;
    logic         save_chi;
    logic         save_hisum;
    logic         out_fire;
  } srse_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic found;
    logic j_lt_u;
    logic j_gt_k;
    logic full;
  } srse_stat_t;

endpackage

@@ src/srse_ctrl.sv @@
module srse_ctrl
  import srse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       action_i,
  input  srse_stat_t stat_i,
  output srse_cmd_t  cmd_o,
  output logic       busy
);

  srse_state_e state_q, state_d;
  srse_phase_e phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_ADD;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_MID;
    busy    = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.ld = 1'b1;
          if (action_i) begin
            cmd_o.srch_init = 1'b1;
            cmd_o.srch_incl = 1'b1;
            cmd_o.srch_x_b  = 1'b1;
            phase_d = PH_QHI;
            state_d = ST_SRD;
          end else if (stat_i.full) begin
            cmd_o.ovf_set = 1'b1;
          end else begin
            cmd_o.cnt_inc   = 1'b1;
            cmd_o.srch_init = 1'b1;
            phase_d = PH_ADD;
            state_d = ST_SRD;
          end
        end
      end
      ST_SRD: begin
        if (stat_i.srch_done) begin
          unique case (phase_q)
            PH_ADD: begin
              if (stat_i.found) begin
                cmd_o.j_init_k = 1'b1;
                state_d = ST_UPD_RD;
              end else begin
                cmd_o.j_init_u = 1'b1;
                state_d = ST_SH_RD;
              end
            end
            PH_QHI: begin
              cmd_o.save_chi  = 1'b1;
              cmd_o.srch_init = 1'b1;
              phase_d = PH_QLO;
            end
            default: begin
              state_d = ST_Q_RD_HI;
            end
          endcase
        end else begin
          cmd_o.rd_sel = RD_MID;
          state_d = ST_SCMP;
        end
      end
      ST_SCMP: begin
        cmd_o.srch_step = 1'b1;
        state_d = ST_SRD;
      end
      ST_UPD_RD: begin
        cmd_o.rd_sel = RD_J;
        state_d = stat_i.j_lt_u ? ST_UPD_WR : ST_IDLE;
      end
      ST_UPD_WR: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.j_inc = 1'b1;
        state_d = ST_UPD_RD;
      end
      ST_SH_RD: begin
        cmd_o.rd_sel = RD_JM1;
        state_d = stat_i.j_gt_k ? ST_SH_WR : ST_INS_RD;
      end
      ST_SH_WR: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.j_dec = 1'b1;
        state_d = ST_SH_RD;
      end
      ST_INS_RD: begin
        cmd_o.rd_sel = RD_KM1;
        state_d = ST_INS_WR;
      end
      ST_INS_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_ins = 1'b1;
        cmd_o.u_inc  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_Q_RD_HI: begin
        cmd_o.rd_sel = RD_CHI_M1;
        state_d = ST_Q_RD_LO;
      end
      ST_Q_RD_LO: begin
        cmd_o.save_hisum = 1'b1;
        cmd_o.rd_sel = RD_CLO_M1;
        state_d = ST_Q_OUT;
      end
      ST_Q_OUT: begin
        cmd_o.out_fire = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/srse_dp.sv @@
module srse_dp
  import srse_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  srse_req_t  request_i,
  input  srse_cmd_t  cmd_i,
  output srse_stat_t stat_o,
  output srse_rsp_t  result_o,
  output logic       valid_o
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic signed [31:0] pos_mem [MAX_ENTRIES];
  logic signed [42:0] pre_mem [MAX_ENTRIES];

  srse_req_t          op_q;
  logic signed [31:0] x_q;
  logic               incl_q, eq_q;
  logic [CW-1:0]      lo_q, hi_q, j_q, u_q, cnt_q, chi_q;
  logic               ovf_q, valid_q;
  logic signed [31:0] pos_rd_q;
  logic signed [42:0] pre_rd_q, hisum_q;
  srse_rsp_t          out_q;

  srse_req_t          src;
  logic [CW-1:0]      mid, k_m1, j_m1, chi_m1, lo_m1;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               take;
  logic signed [42:0] base, val_ext, wr_pre, lo_sum;
  logic signed [31:0] wr_pos;

  assign src     = cmd_i.ld ? request_i : op_q;
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign k_m1    = lo_q - CW'(1);
  assign j_m1    = j_q - CW'(1);
  assign chi_m1  = chi_q - CW'(1);
  assign lo_m1   = lo_q - CW'(1);
  assign take    = incl_q ? (pos_rd_q <= x_q) : (pos_rd_q < x_q);
  assign val_ext = 43'(op_q.second_operand);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_MID:    rd_addr = mid[AW-1:0];
      RD_J:      rd_addr = j_q[AW-1:0];
      RD_JM1:    rd_addr = j_m1[AW-1:0];
      RD_KM1:    rd_addr = k_m1[AW-1:0];
      RD_CHI_M1: rd_addr = chi_m1[AW-1:0];
      RD_CLO_M1: rd_addr = lo_m1[AW-1:0];
      default:   rd_addr = mid[AW-1:0];
    endcase
  end

  always_comb begin
    if (cmd_i.wr_ins) begin
      base    = (lo_q == '0) ? 43'sd0 : pre_rd_q;
      wr_pos  = op_q.first_operand;
      wr_addr = lo_q[AW-1:0];
    end else begin
      base    = pre_rd_q;
      wr_pos  = pos_rd_q;
      wr_addr = j_q[AW-1:0];
    end
    wr_pre = base + val_ext;
  end

  assign lo_sum = (lo_q == '0) ? 43'sd0 : pre_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      pos_mem[wr_addr] <= wr_pos;
      pre_mem[wr_addr] <= wr_pre;
    end
    pos_rd_q <= pos_mem[rd_addr];
    pre_rd_q <= pre_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      op_q <= request_i;
    end
    if (cmd_i.srch_init) begin
      x_q    <= cmd_i.srch_x_b ? src.second_operand : src.first_operand;
      incl_q <= cmd_i.srch_incl;
      eq_q   <= 1'b0;
      lo_q   <= '0;
      hi_q   <= u_q;
    end else if (cmd_i.srch_step) begin
      if (take) begin
        lo_q <= mid + CW'(1);
      end else begin
        hi_q <= mid;
      end
      if (pos_rd_q == x_q) begin
        eq_q <= 1'b1;
      end
    end
    if (cmd_i.j_init_k) begin
      j_q <= lo_q;
    end else if (cmd_i.j_init_u) begin
      j_q <= u_q;
    end else if (cmd_i.j_inc) begin
      j_q <= j_q + CW'(1);
    end else if (cmd_i.j_dec) begin
      j_q <= j_m1;
    end
    if (cmd_i.save_chi) begin
      chi_q <= lo_q;
    end
    if (cmd_i.save_hisum) begin
      hisum_q <= (chi_q == '0) ? 43'sd0 : pre_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q     <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
      out_q   <= '0;
    end else begin
      if (cmd_i.u_inc) begin
        u_q <= u_q + CW'(1);
      end
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.ovf_set) begin
        ovf_q <= 1'b1;
      end
      valid_q <= cmd_i.out_fire;
      if (cmd_i.out_fire) begin
        out_q.range_sum    <= hisum_q - lo_sum;
        out_q.adds_dropped <= ovf_q;
      end
    end
  end

  assign stat_o.srch_done = (lo_q >= hi_q);
  assign stat_o.found     = eq_q;
  assign stat_o.j_lt_u    = (j_q < u_q);
  assign stat_o.j_gt_k    = (j_q > lo_q);
  assign stat_o.full      = (cnt_q == CW'(MAX_ENTRIES));

  assign result_o = out_q;
  assign valid_o  = valid_q;

endmodule

@@ src/sparse_range_sum_engine_unit.sv @@
// Range-sum engine over a sparse signed 32-bit position space.
// A request is taken when start is high and busy is low. An add request
// (action 0) adds a signed value at a position; a query request (action 1)
// returns the sum of values at positions from left to right inclusive.
// The engine keeps a sorted table of distinct positions with running sums,
// held in two memories with one read and one write port each, and keeps it
// sorted as adds arrive.
// An add takes one binary search plus a read and a write for each table
// entry that is moved or updated.
// An add beyond MAX_ENTRIES stored adds is dropped and sets a
// sticky flag that is reported with every later result.
// A query takes two binary searches and two memory reads; its result appears
// on result_o with valid_o high for exactly one cycle. The receiver cannot
// stall the engine.
// Reset empties the table and clears the drop flag; no clearing pass runs.
module sparse_range_sum_engine_unit
  import srse_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  srse_req_t request_i,
  output srse_rsp_t result_o,
  output logic      valid_o
);

  srse_cmd_t  cmd;
  srse_stat_t stat;

  srse_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (request_i.action),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  srse_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .request_i (request_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .result_o  (result_o),
    .valid_o   (valid_o)
  );

endmodule

@@ src/srse_checker.sv @@
module srse_checker
  import srse_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input srse_req_t request_i,
  input srse_rsp_t result_o,
  input logic      valid_o
);

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result shown while busy");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result held for more than one cycle");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && request_i.action) |=> busy)
    else $error("query request did not occupy the engine");

  a_drop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(result_o.adds_dropped)) else $error("drop flag cleared");

endmodule

bind sparse_range_sum_engine_unit srse_checker u_srse_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .request_i (request_i),
  .result_o  (result_o),
  .valid_o   (valid_o)
);

@@ bench/range_sum_checker.sv @@
`timescale 1ns / 1ps
module range_sum_checker
  import srse_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      busy,
  input  srse_req_t request_i,
  input  srse_rsp_t result_o,
  input  logic      valid_o,
  output int        fail_count,
  output int        sums_pending,
  output int        sums_checked
);

  logic signed [31:0] add_pos[MAX_ENTRIES];
  logic signed [31:0] add_val[MAX_ENTRIES];
  int                 add_count;
  logic               dropped_seen;
  srse_rsp_t          sums_due[$];

  function automatic srse_rsp_t predict_range_sum(logic signed [31:0] left,
                                                  logic signed [31:0] right);
    longint    upto_right;
    longint    below_left;
    longint    diff;
    srse_rsp_t rsp;
    upto_right = 0;
    below_left = 0;
    for (int i = 0; i < add_count; i++) begin
      if (add_pos[i] <= right) upto_right += longint'(add_val[i]);
      if (add_pos[i] < left) below_left += longint'(add_val[i]);
    end
    diff = upto_right - below_left;
    rsp.range_sum = diff[42:0];
    rsp.adds_dropped = dropped_seen;
    return rsp;
  endfunction

  assign sums_pending = sums_due.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    srse_rsp_t want;
    if (!rst_ni) begin
      add_count <= 0;
      dropped_seen <= 1'b0;
      fail_count <= 0;
      sums_checked <= 0;
      sums_due.delete();
    end else begin
      if (valid_o) begin
        sums_checked <= sums_checked + 1;
        if (sums_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with nothing expected: sum %0d dropped %0b", $time,
                     result_o.range_sum, result_o.adds_dropped);
          fail_count <= fail_count + 1;
        end else begin
          want = sums_due.pop_front();
          if (result_o.range_sum !== want.range_sum ||
              result_o.adds_dropped !== want.adds_dropped) begin
            if (fail_count < 10)
              $display("%0t: mismatch: sum exp %0d got %0d, dropped exp %0b got %0b",
                       $time, want.range_sum, result_o.range_sum, want.adds_dropped,
                       result_o.adds_dropped);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (request_i.action) begin
          sums_due.insert(sums_due.size(),
                          predict_range_sum(request_i.first_operand,
                                            request_i.second_operand));
        end else if (add_count < MAX_ENTRIES) begin
          add_pos[add_count] <= request_i.first_operand;
          add_val[add_count] <= request_i.second_operand;
          add_count <= add_count + 1;
        end else begin
          dropped_seen <= 1'b1;
        end
      end
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import srse_pkg::*;

  localparam int     MAX_ENTRIES = 1024;
  localparam longint CYCLE_LIMIT = 8_000_000;
  localparam bit     ACT_ADD = 1'b0;
  localparam bit     ACT_QUERY = 1'b1;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  srse_req_t request_i;
  srse_rsp_t result_o;
  logic      valid_o;
  int        fail_count;
  int        sums_pending;
  int        sums_checked;
  longint    cycles = 0;
  int        adds_sent;
  int        queries_sent;
  int        idle_pct;
  logic signed [31:0] pos_pool[48];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  sparse_range_sum_engine_unit #(.MAX_ENTRIES(MAX_ENTRIES)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .request_i(request_i), .result_o(result_o), .valid_o(valid_o)
  );

  range_sum_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .request_i(request_i), .result_o(result_o), .valid_o(valid_o),
    .fail_count(fail_count), .sums_pending(sums_pending), .sums_checked(sums_checked)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send(input logic act, input logic signed [31:0] a,
                      input logic signed [31:0] b);
    bit taken;
    start <= 1'b1;
    request_i <= '{action: act, first_operand: a, second_operand: b};
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    if (act == ACT_QUERY) queries_sent++;
    else adds_sent++;
  endtask

  task automatic maybe_idle();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      request_i <= '{action: 1'($urandom), first_operand: $urandom,
                     second_operand: $urandom};
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    wait (sums_pending == 0);
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_pos();
    logic signed [31:0] p;
    p = pos_pool[$urandom_range(47)];
    case ($urandom_range(9))
      0: p = p - 1;
      1: p = p + 1;
      2: p = $urandom;
      default: ;
    endcase
    return p;
  endfunction

  task automatic random_item();
    logic signed [31:0] l;
    logic signed [31:0] r;
    logic signed [31:0] v;
    if ($urandom_range(99) < 45 && adds_sent < 1000) begin
      v = ($urandom_range(3) == 0) ? $signed($urandom_range(200)) - 100 : $urandom;
      if ($urandom_range(19) == 0) send(ACT_ADD, $urandom, v);
      else send(ACT_ADD, pos_pool[$urandom_range(47)], v);
    end else begin
      l = pick_pos();
      r = pick_pos();
      if ($urandom_range(3) != 0 && l > r) send(ACT_QUERY, r, l);
      else send(ACT_QUERY, l, r);
    end
    maybe_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    request_i = '0;
    adds_sent = 0;
    queries_sent = 0;
    idle_pct = 0;
    for (int i = 0; i < 48; i++)
      pos_pool[i] = (i < 16) ? $signed($urandom_range(40)) - 20 : $urandom;
    pos_pool[0] = 32'sh8000_0000;
    pos_pool[1] = 32'sh7fff_ffff;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(ACT_QUERY, 32'sh8000_0000, 32'sh7fff_ffff);
    send(ACT_QUERY, 0, 0);
    send(ACT_ADD, 32'sh8000_0000, 32'sh7fff_ffff);
    send(ACT_ADD, 32'sh7fff_ffff, 32'sh8000_0000);
    send(ACT_ADD, 0, -1);
    send(ACT_ADD, 0, 5);
    send(ACT_ADD, 3, 32'sh7fff_ffff);
    send(ACT_QUERY, 32'sh8000_0000, 32'sh7fff_ffff);
    send(ACT_QUERY, 32'sh7fff_ffff, 32'sh8000_0000);
    send(ACT_QUERY, 0, 0);
    send(ACT_QUERY, 32'sh8000_0000, 32'sh8000_0000);
    send(ACT_QUERY, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send(ACT_QUERY, 1, 0);
    send(ACT_QUERY, 0, -1);
    send(ACT_QUERY, 1, -1);
    send(ACT_QUERY, 4, 2);
    send(ACT_ADD, 3, 32'sh8000_0000);
    send(ACT_QUERY, -5, 5);
    send(ACT_QUERY, 32'sh7fff_ffff, 32'sh8000_0000);
    drain();

    idle_pct = 8;
    repeat (415) random_item();
    drain();
    idle_pct = 69;
    repeat (415) random_item();
    idle_pct = 0;
    repeat (415) random_item();
    drain();

    // Fill the store with repeated positions, then push a few adds past capacity.
    while (adds_sent < MAX_ENTRIES + 6)
      send(ACT_ADD, pos_pool[$urandom_range(15)], $urandom);
    repeat (20) begin
      send(ACT_QUERY, pick_pos(), pick_pos());
      maybe_idle();
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("tb: %0d adds and %0d queries sent, %0d sums checked, %0d mismatches",
             adds_sent, queries_sent, sums_checked, fail_count);
    $display("tb: covered bound extremes, reversed ranges and store overflow");
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
